/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rcd_pkg.sv */
// Package with shared types, constants and helpers for the radix converter.
`timescale 1ns / 1ps

package rcd_pkg;

  localparam int ValueW = 31;
  localparam int BaseW  = 5;
  localparam int DigitW = 4;
  localparam int CharW  = 7;
  localparam int AddrW  = 2;
  localparam int DataW  = 32;

  localparam logic [BaseW-1:0] BaseMin   = 5'd2;
  localparam logic [BaseW-1:0] BaseMax   = 5'd16;
  localparam logic [BaseW-1:0] BaseReset = 5'd10;

  // Register byte addresses
  localparam logic [AddrW-1:0] RegTargetBase = 2'd0;

  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharA    = 7'h41;

  // One conversion job handed from front to back
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [BaseW-1:0]  base;
  } rcd_job_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d <= 4'd9) begin
      c = CharZero + {3'b000, d};
    end else begin
      c = CharA + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    if (b < BaseMin) begin
      r = BaseMin;
    end else if (b > BaseMax) begin
      r = BaseMax;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

/* rtl/core/rcd_if.sv */
// Valid/ready channel interfaces for number input and digit output.
`timescale 1ns / 1ps

interface rcd_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcd_pkg::ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rcd_out_if;
  logic                      valid;
  logic                      ready;
  logic [rcd_pkg::CharW-1:0] digit_char;
  logic                      last_digit;
  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* rtl/core/rcd_front.sv */
// Front stage: takes number transfers, clamps the base and stages the job.
`timescale 1ns / 1ps

module rcd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rcd_in_if.sink                   item,
  input  logic [rcd_pkg::BaseW-1:0] base_i,
  output logic                     job_valid_o,
  output rcd_pkg::rcd_job_t        job_o,
  input  logic                     job_ready_i
);
  import rcd_pkg::*;

  logic     valid_q, valid_d;
  rcd_job_t job_q;
  logic     accept;

  assign item.ready  = !valid_q || job_ready_i;
  assign accept      = item.valid && item.ready;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // out-of-range bases fold to the nearest legal radix
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.value <= item.value;
      job_q.base  <= clamp_base(base_i);
    end
  end

endmodule

/* rtl/core/rcd_queue.sv */
// Two-entry job queue between front and back.
`timescale 1ns / 1ps

module rcd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  rcd_pkg::rcd_job_t push_job_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output rcd_pkg::rcd_job_t pop_job_o,
  input  logic              pop_ready_i
);
  import rcd_pkg::*;

  rcd_job_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* rtl/core/rcd_back.sv */
// Back stage: divides into digits on a stack, then pops them out as ASCII.
`timescale 1ns / 1ps

module rcd_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  rcd_pkg::rcd_job_t job_i,
  output logic              job_ready_o,
  rcd_out_if.source         out
);
  import rcd_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPop  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [31:0]      num_q, num_d;
  logic [BaseW-1:0] rem_q, rem_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [SPW-1:0]   sp_dec;

  logic [DigitW-1:0] stack_mem [STACK_DEPTH];
  logic [DigitW-1:0] rd_data_q;
  logic              rd_last_q;
  logic              rd_pend_q, rd_pend_d;

  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;

  logic [BaseW-1:0]  div_rem;
  logic [31:0]       div_quot;
  logic              push_en, pop_en, out_move;

  // restoring division, eight quotient bits per cycle
  always_comb begin
    logic [BaseW-1:0] r;
    logic [31:0]      w;
    r = rem_q;
    w = num_q;
    for (int i = 0; i < 8; i++) begin
      r = {r[3:0], w[31]};
      w = {w[30:0], 1'b0};
      if (r >= base_q) begin
        r    = r - base_q;
        w[0] = 1'b1;
      end
    end
    div_rem  = r;
    div_quot = w;
  end

  assign sp_dec   = sp_q - SPW'(1);
  assign out_move = rd_pend_q && (!out_valid_q || out.ready);
  assign pop_en   = (state_q == StPop) && (sp_q != '0) && (!rd_pend_q || out_move);
  assign job_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    push_en = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          num_d   = {1'b0, job_i.value};
          base_d  = job_i.base;
          rem_d   = '0;
          cnt_d   = 2'd0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        num_d = div_quot;
        rem_d = div_rem;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          // one digit done: push remainder, go again on the quotient
          push_en = (sp_q < SPW'(STACK_DEPTH));
          rem_d   = '0;
          if (div_quot == '0) begin
            state_d = StPop;
          end
        end
      end
      StPop: begin
        if (pop_en && (sp_q == SPW'(1))) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    if (push_en) begin
      sp_d = sp_q + SPW'(1);
    end else if (pop_en) begin
      sp_d = sp_dec;
    end
    rd_pend_d = pop_en ? 1'b1 : (out_move ? 1'b0 : rd_pend_q);
    out_valid_d = out_move ? 1'b1 : (out.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= 2'd0;
      sp_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    base_q <= base_d;
  end

  // digit stack: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[sp_q[AW-1:0]] <= div_rem[DigitW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_en) begin
      rd_data_q <= stack_mem[sp_dec[AW-1:0]];
      rd_last_q <= (sp_q == SPW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      out_char_q <= digit_to_ascii(rd_data_q);
      out_last_q <= rd_last_q;
    end
  end

  assign out.valid      = out_valid_q;
  assign out.digit_char = out_char_q;
  assign out.last_digit = out_last_q;

endmodule

/* rtl/core/radix_convert_digits.sv */
// Top level of the radix converter: APB register, front, queue and back.
//
//   channel  | dir | payload                 | transfer when
//   ---------+-----+-------------------------+--------------------------
//   item_i   | in  | value[30:0]             | valid && ready
//   digit_o  | out | digit_char[6:0], last   | valid && ready
//   apb      | in  | target_base @ 0x0       | psel && penable && pwrite
//
// Back stage: each digit of a number comes from the restoring divider (8 quotient
//   bits per cycle), then the digits are popped off the stack. Base 2 with a
//   full 31-bit value is the worst case, with the most digits.
// The front stage and a two-entry queue take further numbers while the back
//   stage works, so input transfers stall only when the queue is full.
// Reset: async active low; the stack needs no clearing, its pointer resets.
// Output stalls hold the digit in the output register; the stack pop waits.
`timescale 1ns / 1ps

module radix_convert_digits #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rcd_in_if.sink                   item_i,
  rcd_out_if.source                digit_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [rcd_pkg::AddrW-1:0] paddr,
  input  logic [rcd_pkg::DataW-1:0] pwdata,
  output logic [rcd_pkg::DataW-1:0] prdata,
  output logic                     pready
);
  import rcd_pkg::*;

  logic [BaseW-1:0] base_q;
  logic             cfg_we;

  logic     fr_valid, fr_ready;
  rcd_job_t fr_job;
  logic     bk_valid, bk_ready;
  rcd_job_t bk_job;

  // config register; the user must write it only while no number is in flight, the block does not enforce this
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == RegTargetBase);
  assign prdata = (paddr == RegTargetBase) ? {{(DataW-BaseW){1'b0}}, base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_we) begin
      base_q <= pwdata[BaseW-1:0];
    end
  end

  rcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item        (item_i),
    .base_i      (base_q),
    .job_valid_o (fr_valid),
    .job_o       (fr_job),
    .job_ready_i (fr_ready)
  );

  rcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_job_i   (fr_job),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_job_o    (bk_job),
    .pop_ready_i  (bk_ready)
  );

  rcd_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_i       (bk_job),
    .job_ready_o (bk_ready),
    .out         (digit_o)
  );

endmodule

/* rtl/core/rcd_checker.sv */
// Port-level checker for the radix converter and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rcd_pkg::CharW-1:0] digit_char_i,
  input logic                      last_digit_i,
  input logic                      psel_i,
  input logic                      penable_i,
  input logic                      pwrite_i,
  input logic [rcd_pkg::AddrW-1:0] paddr_i,
  input logic [rcd_pkg::DataW-1:0] pwdata_i,
  input logic [rcd_pkg::DataW-1:0] prdata_i
);
  import rcd_pkg::*;

  `RCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(digit_char_i) && $stable(last_digit_i),
    "stalled digit changed or dropped")

  `RCD_ASSERT_SAME(a_char_legal, clk_i, rst_ni, out_valid_i,
    ((digit_char_i >= CharZero) && (digit_char_i <= CharZero + 7'd9)) ||
    ((digit_char_i >= CharA) && (digit_char_i <= CharA + 7'd5)),
    "digit character outside 0-9 / A-F")

  `RCD_ASSERT_SAME(a_reset_quiet, clk_i, rst_ni, $rose(rst_ni), !out_valid_i,
    "digit valid right after reset release")

  `RCD_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni,
    psel_i && penable_i && pwrite_i && (paddr_i == RegTargetBase),
    (paddr_i != RegTargetBase) || (prdata_i[BaseW-1:0] == $past(pwdata_i[BaseW-1:0])),
    "target base readback differs from written value")

endmodule

bind radix_convert_digits rcd_checker u_rcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (digit_o.valid),
  .out_ready_i  (digit_o.ready),
  .digit_char_i (digit_o.digit_char),
  .last_digit_i (digit_o.last_digit),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);
